// ===== rtl/core/led_mux_scan_with_random_flicker_top_defines.svh =====
// Assertion macros for the LED mux scan block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef LED_MUX_SCAN_WITH_RANDOM_FLICKER_TOP_DEFINES_SVH
`define LED_MUX_SCAN_WITH_RANDOM_FLICKER_TOP_DEFINES_SVH

// Clocked assertion, off while in reset.
`define LMSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LMSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lmsf_pkg.sv =====
// Shared types and constants for the LED mux scan with random flicker.
// No dependencies.
package lmsf_pkg;

  localparam int LED_COUNT = 4;
  localparam int LED_IDX_W = $clog2(LED_COUNT);
  localparam int PADDR_W   = 3;

  localparam logic [PADDR_W-1:0] ADDR_FLAME = 3'd0;

  localparam logic [31:0] SEED_INIT = 32'h2a651b7d;
  localparam logic [31:0] LCG_MUL   = 32'd1664525;
  localparam logic [31:0] LCG_INC   = 32'd1013904223;

  localparam logic [7:0]        LVL_BASE = 8'd90;
  localparam logic [7:0]        LVL_SPAN = 8'd166;
  localparam logic signed [8:0] CD_BASE  = 9'sd50;
  localparam logic [7:0]        CD_SPAN  = 8'd180;
  localparam logic signed [8:0] CD_STEP  = 9'sd40;
  localparam logic signed [8:0] CD_MIN   = -9'sd40;
  localparam logic signed [8:0] CD_MAX   = 9'sd229;

  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REFRESH = 1'b1;

  typedef struct packed {
    logic command;
    logic num_lock;
    logic caps_lock;
    logic scroll_lock;
    logic accent_active;
  } in_beat_t;

  typedef struct packed {
    logic       select_a;
    logic       select_b;
    logic       led_gate;
    logic [1:0] slot;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK_RND,
    ST_TICK_CMP,
    ST_PUT,
    ST_REF_DEC,
    ST_REF_RND1,
    ST_REF_LVL,
    ST_REF_RND2,
    ST_REF_CD
  } state_t;

endpackage

// ===== rtl/core/led_mux_scan_with_random_flicker_top.sv =====
// LED mux scan with random flicker: a tick draws (ST_TICK_RND, ST_TICK_CMP)
// when its slot is lit in flame mode, then ST_PUT; a refresh loads the mask
// and, in flame mode, walks four LEDs, each up to 5 sequencer steps through
// one shared LCG unit. One beat at a time; in_ready returns once the sequencer
// is back in idle, which a stalled result delays. rst_n is synchronous, active
// low: slot, mask, levels, countdowns, seed, flame reset. Depends on lmsf_pkg.
`include "led_mux_scan_with_random_flicker_top_defines.svh"

module led_mux_scan_with_random_flicker_top
  import lmsf_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  in_beat_t           in_data,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_t                state_r, state_nxt;
  logic                  flame_r, flame_nxt;
  logic [1:0]            scan_slot_r, scan_slot_nxt;
  logic [LED_COUNT-1:0]  lit_mask_r, lit_mask_nxt;
  logic [7:0]            level_r [LED_COUNT];
  logic [7:0]            level_nxt [LED_COUNT];
  logic signed [8:0]     cd_r [LED_COUNT];
  logic signed [8:0]     cd_nxt [LED_COUNT];
  logic [31:0]           seed_r, seed_nxt;
  logic [LED_IDX_W-1:0]  led_r, led_nxt;
  logic                  gate_r, gate_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r, out_data_nxt;

  // ---------------------------------------------------------------------
  // Shared units: LCG step, and one compare/subtract reduction of the
  // random byte (byte < 256 < 2*span, so one subtract is a full modulo).
  // ---------------------------------------------------------------------
  logic [31:0]       lcg_nxt;
  logic [7:0]        rnd_byte;
  logic [7:0]        mod_span;
  logic [7:0]        mod_res;
  logic [1:0]        slot_inc;
  logic signed [8:0] cd_dec;
  logic              led_last;
  logic              in_beat;
  logic              cfg_wr;
  logic              slot_draw;

  assign lcg_nxt  = seed_r * LCG_MUL + LCG_INC;
  assign rnd_byte = seed_r[31:24];
  assign mod_span = (state_r == ST_REF_LVL) ? LVL_SPAN : CD_SPAN;
  assign mod_res  = (rnd_byte >= mod_span) ? rnd_byte - mod_span : rnd_byte;

  assign slot_inc  = scan_slot_r + 2'd1;
  assign slot_draw = lit_mask_r[slot_inc] & flame_r;
  assign cd_dec    = cd_r[led_r] - CD_STEP;
  assign led_last  = (led_r == LED_IDX_W'(LED_COUNT - 1));

  assign in_ready = (state_r == ST_IDLE);
  assign in_beat  = in_valid & in_ready;

  // APB: writes land on the access phase; reads are combinational
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr == ADDR_FLAME) ? {31'd0, flame_r} : 32'd0;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_data.command == CMD_TICK) begin
            state_nxt = slot_draw ? ST_TICK_RND : ST_PUT;
          end else begin
            state_nxt = flame_r ? ST_REF_DEC : ST_IDLE;
          end
        end
      end
      ST_TICK_RND: state_nxt = ST_TICK_CMP;
      ST_TICK_CMP: state_nxt = ST_PUT;
      ST_PUT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      ST_REF_DEC: begin
        if (cd_dec <= 0)   state_nxt = ST_REF_RND1;
        else if (led_last) state_nxt = ST_IDLE;
      end
      ST_REF_RND1: state_nxt = ST_REF_LVL;
      ST_REF_LVL:  state_nxt = ST_REF_RND2;
      ST_REF_RND2: state_nxt = ST_REF_CD;
      ST_REF_CD:   state_nxt = led_last ? ST_IDLE : ST_REF_DEC;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath / outputs
  // ---------------------------------------------------------------------
  always_comb begin
    flame_nxt     = flame_r;
    scan_slot_nxt = scan_slot_r;
    lit_mask_nxt  = lit_mask_r;
    level_nxt     = level_r;
    cd_nxt        = cd_r;
    seed_nxt      = seed_r;
    led_nxt       = led_r;
    gate_nxt      = gate_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cfg_wr && paddr == ADDR_FLAME) flame_nxt = pwdata[0];

    // result leaves the output register
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (in_data.command == CMD_TICK) begin
            scan_slot_nxt = slot_inc;
            gate_nxt      = lit_mask_r[slot_inc];
          end else begin
            lit_mask_nxt = {in_data.accent_active, in_data.scroll_lock,
                            in_data.caps_lock, in_data.num_lock};
            led_nxt      = '0;
          end
        end
      end
      ST_TICK_RND, ST_REF_RND1, ST_REF_RND2: seed_nxt = lcg_nxt;
      ST_TICK_CMP: gate_nxt = (rnd_byte < level_r[scan_slot_r]);
      ST_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.select_a = scan_slot_r[0];
          out_data_nxt.select_b = scan_slot_r[1];
          out_data_nxt.led_gate = gate_r;
          out_data_nxt.slot     = scan_slot_r;
        end
      end
      ST_REF_DEC: begin
        cd_nxt[led_r] = cd_dec;
        // no redraw: move straight on to the next LED
        if (cd_dec > 0 && !led_last) led_nxt = led_r + 1'b1;
      end
      ST_REF_LVL: level_nxt[led_r] = LVL_BASE + mod_res;
      ST_REF_CD: begin
        cd_nxt[led_r] = CD_BASE + $signed({1'b0, mod_res});
        if (!led_last) led_nxt = led_r + 1'b1;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      flame_r     <= 1'b0;
      scan_slot_r <= '0;
      lit_mask_r  <= '0;
      seed_r      <= SEED_INIT;
      led_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        level_r[i] <= '0;
        cd_r[i]    <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      flame_r     <= flame_nxt;
      scan_slot_r <= scan_slot_nxt;
      lit_mask_r  <= lit_mask_nxt;
      seed_r      <= seed_nxt;
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
      level_r     <= level_nxt;
      cd_r        <= cd_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    gate_r     <= gate_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `LMSF_ASSERT(a_tick_advances, in_beat && in_data.command == CMD_TICK |=> scan_slot_r == 2'($past(scan_slot_r) + 2'd1), "scan slot did not advance on tick")
  `LMSF_ASSERT(a_cd_range, state_r == ST_REF_DEC |-> cd_r[led_r] >= CD_MIN && cd_r[led_r] <= CD_MAX, "countdown out of range")
  `LMSF_ASSERT(a_seed_idle, state_r == ST_IDLE |=> $stable(seed_r), "seed moved outside a draw step")

endmodule
